@@ src/lpl_pkg.sv @@
// ----------------------------------------------------------------------------
// Lookahead peak limiter package
// Shared widths, fixed-point constants and configuration register codes.
// ----------------------------------------------------------------------------
package lpl_pkg;

  localparam int MAX_DELAY_DEF   = 512;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CEIL_W     = 16;
  localparam int GAIN_W     = 20;
  localparam int LA_W       = 10;
  localparam int RF_W       = 24;
  localparam int LG_W       = 25;
  localparam int G16_W      = 17;
  localparam int CNT_W      = 40;
  localparam int NRG_W      = 62;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [G16_W-1:0]  UNITY16   = G16_W'(65536);
  localparam logic [LG_W-1:0]   UNITY24   = LG_W'(16777216);
  localparam logic [LG_W-1:0]   LIMIT_THR = LG_W'(16760439);
  localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(65536);

  localparam logic [CEIL_W-1:0] CEIL_RST = CEIL_W'(32768);
  localparam logic [LA_W-1:0]   LA_RST   = LA_W'(48);
  localparam logic [RF_W-1:0]   RF_RST   = RF_W'(2330);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CEILING   = 3'd0,
    CFG_TARGET    = 3'd1,
    CFG_RAMP      = 3'd2,
    CFG_LOOKAHEAD = 3'd3,
    CFG_RELEASE   = 3'd4
  } cfg_reg_e;

endpackage

@@ src/lpl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, read data registered (read before write).
// ----------------------------------------------------------------------------
module lpl_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [W-1:0]  wdata_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ src/lpl_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiply with the product registered; the result appears in the cycle after the operands.
// ----------------------------------------------------------------------------
module lpl_mul #(
  parameter int MA = 25,
  parameter int MB = 25
) (
  input  logic             clk_i,
  input  logic [MA-1:0]    a_i,
  input  logic [MB-1:0]    b_i,
  output logic [MA+MB-1:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= (MA + MB)'(a_i) * (MA + MB)'(b_i);
  end

endmodule

@@ src/lpl_div.sv @@
// ----------------------------------------------------------------------------
// Restoring divider
// Produces QW quotient bits of num/den, one bit a cycle, for num < den.
// ----------------------------------------------------------------------------
module lpl_div #(
  parameter int DW = 21,
  parameter int QW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, 1'b0};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_o <= 1'b0;
      cnt_q  <= CW'(QW);
      rem_q  <= num_i;
      den_q  <= den_i;
      quo_o  <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      quo_o  <= {quo_o[QW-2:0], fits};
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CW'(1));
      done_o <= (cnt_q == CW'(1));
    end else begin
      done_o <= 1'b0;
    end
  end

endmodule

@@ src/lookahead_peak_limiter.sv @@
// ----------------------------------------------------------------------------
// Lookahead peak limiter
// Boost ramp, lookahead sliding-minimum gain computer, delay line and meters.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries one sample and produces exactly
// one result transfer. The time a sample takes grows with every entry popped
// from the gain deque; it is set by the sequencer that drives one shared
// multiplier through five products, the restoring divider for the needed
// gain and the single-port deque memory, read once per pop. While a sample
// is being worked on, in_stall_o is high. After reset the delay memory is
// cleared in one pass over its MAX_DELAY words, during which no sample is
// accepted; configuration writes are taken at any time but should only be
// made while the block is idle. A finished result sits in the output
// register, so the next sample can be accepted before it is taken.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter import lpl_pkg::*; #(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          clear_meters_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic [GAIN_W-1:0]             boost_gain_now_o,
  output logic [G16_W-1:0]              limiter_gain_now_o,
  output logic                          is_limiting_o,
  output logic [SAMPLE_BITS-1:0]        peak_in_o,
  output logic [SAMPLE_BITS-1:0]        peak_out_o,
  output logic [G16_W-1:0]              least_limiter_gain_o,
  output logic [CNT_W-1:0]              limited_total_o,
  output logic [CNT_W-1:0]              sample_total_o,
  output logic [NRG_W-1:0]              energy_in_o,
  output logic [NRG_W-1:0]              energy_out_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int SB        = SAMPLE_BITS;
  localparam int YW        = SB + 5;              // boosted sample in the delay line
  localparam int FULL      = 1 << (SB - 1);
  localparam int STORE_MAX = (1 << (SB + 4)) - 1;
  localparam int LW        = $clog2(MAX_DELAY + 1);
  localparam int PW        = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int SMOD      = 2 * MAX_DELAY;
  localparam int SW        = $clog2(SMOD);
  localparam int DQ        = MAX_DELAY + 1;
  localparam int QIW       = $clog2(DQ);
  localparam int FW        = $clog2(DQ + 1);
  localparam int VW        = G16_W;
  localparam int MA        = (YW > LG_W) ? YW : LG_W;
  localparam int MB        = LG_W;
  localparam int MP        = MA + MB;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EIN, S_BOOST, S_DIV, S_POPB, S_POPB_CHK, S_PUSH,
    S_POPF, S_POPF_CHK, S_REL, S_REL_W, S_OMUL, S_OMUL_W, S_EOUT, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [CEIL_W-1:0] ceiling_q;
  logic [GAIN_W-1:0] target_q, ramp_q;
  logic [LA_W-1:0]   la_q;
  logic [RF_W-1:0]   rf_q;

  // Processing state
  logic [GAIN_W-1:0]   bg_q;
  logic [LG_W-1:0]     lg_q, desired_q;
  logic [PW-1:0]       ptr_q, clr_q;
  logic [SW-1:0]       sn_q, n_q;
  logic [QIW-1:0]      head_q, tail_q;
  logic [FW-1:0]       fill_q;
  logic [SB-1:0]       ax_q;
  logic                neg_q, need_q;
  logic [YW-1:0]       y_q, delayed_q;
  logic [VW-1:0]       r_q, gain16_q;
  logic                lim_q;
  logic signed [SB-1:0] o_q;

  // Meters
  logic [SB-1:0]    pk_in_q, pk_out_q;
  logic [G16_W-1:0] least_q;
  logic [CNT_W-1:0] cnt_lim_q, cnt_all_q;
  logic [NRG_W-1:0] nrg_in_q, nrg_out_q;

  // Combinational helpers
  logic [LW-1:0]     len_c;
  logic [SB-1:0]     ceil_eff, pos_lim, ax_in, omag_c;
  logic [GAIN_W-1:0] ramp_dist, bg_next;
  logic [MA-1:0]     mul_a;
  logic [MB-1:0]     mul_b;
  logic [MP-1:0]     mul_p, p_rnd, p_lim, o_rnd;
  logic [YW-1:0]     ymag_c, dmag;
  logic [QIW-1:0]    last_c;
  logic [SW-1:0]     stamp_c;
  logic [SW:0]       age_c;
  logic [NRG_W:0]    nrg_sum;
  logic [NRG_W-1:0]  nrg_base;
  logic              div_start, div_done;
  logic [15:0]       div_q;
  logic              dly_we;
  logic [PW-1:0]     dly_addr;
  logic [YW-1:0]     dly_wdata, dly_rdata;
  logic              wq_we;
  logic [QIW-1:0]    wq_addr;
  logic [SW+VW-1:0]  wq_rdata;

  assign in_stall_o = (state_q != S_IDLE);

  // Effective lookahead length and ceiling.
  always_comb begin
    if (la_q == '0) begin
      len_c = LW'(1);
    end else if (32'(la_q) > MAX_DELAY) begin
      len_c = LW'(MAX_DELAY);
    end else begin
      len_c = LW'(la_q);
    end
    ceil_eff = (32'(ceiling_q) > FULL) ? SB'(FULL) : SB'(ceiling_q);
    pos_lim  = (32'(ceil_eff) > FULL - 1) ? SB'(FULL - 1) : ceil_eff;
  end

  assign ax_in = sample_in_i[SB-1] ? SB'(-sample_in_i) : SB'(sample_in_i);

  // Boost ramp towards its target.
  always_comb begin
    ramp_dist = (target_q > bg_q) ? target_q - bg_q : bg_q - target_q;
    bg_next   = bg_q;
    if (bg_q != target_q) begin
      if (ramp_q == '0 || ramp_dist <= ramp_q) begin
        bg_next = target_q;
      end else if (target_q > bg_q) begin
        bg_next = bg_q + ramp_q;
      end else begin
        bg_next = bg_q - ramp_q;
      end
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_IDLE: begin
        mul_a = MA'(ax_in);
        mul_b = MB'(ax_in);
      end
      S_EIN: begin
        mul_a = MA'(ax_q);
        mul_b = MB'(bg_q);
      end
      S_REL: begin
        mul_a = MA'(desired_q - lg_q);
        mul_b = MB'(rf_q);
      end
      S_OMUL: begin
        mul_a = MA'(dmag);
        mul_b = MB'(lg_q);
      end
      S_OMUL_W: begin
        mul_a = MA'(omag_c);
        mul_b = MB'(omag_c);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lpl_mul #(.MA(MA), .MB(MB)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Boosted magnitude, rounded and saturated to the delay-line width.
  always_comb begin
    p_rnd  = (mul_p + MP'(32768)) >> 16;
    p_lim  = neg_q ? MP'(STORE_MAX) + MP'(1) : MP'(STORE_MAX);
    ymag_c = (p_rnd > p_lim) ? YW'(p_lim) : YW'(p_rnd);
  end

  assign div_start = (state_q == S_BOOST);

  lpl_div #(.DW(YW), .QW(16)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (YW'(ceil_eff)),
    .den_i   (ymag_c),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // Delay line: cleared after reset, then read and written at the pointer.
  assign dly_we    = (state_q == S_CLEAR) || (state_q == S_DIV && div_done);
  assign dly_addr  = (state_q == S_CLEAR) ? clr_q : ptr_q;
  assign dly_wdata = (state_q == S_CLEAR) ? '0 : y_q;

  lpl_ram #(.W(YW), .D(MAX_DELAY)) u_dly (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .addr_i  (dly_addr),
    .wdata_i (dly_wdata),
    .rdata_o (dly_rdata)
  );

  assign dmag = delayed_q[YW-1] ? YW'(-delayed_q) : delayed_q;

  // Gain deque: {stamp, value} words in a circular buffer.
  assign last_c  = (tail_q == '0) ? QIW'(DQ - 1) : tail_q - 1'b1;
  assign wq_we   = (state_q == S_PUSH);
  assign stamp_c = wq_rdata[SW+VW-1:VW];
  assign age_c   = (n_q >= stamp_c) ? (SW + 1)'(n_q - stamp_c)
                                    : (SW + 1)'(32'(n_q) + SMOD - 32'(stamp_c));

  always_comb begin
    unique case (state_q)
      S_POPB, S_POPB_CHK: wq_addr = last_c;
      S_PUSH:             wq_addr = tail_q;
      default:            wq_addr = head_q;
    endcase
  end

  lpl_ram #(.W(SW + VW), .D(DQ)) u_wq (
    .clk_i   (clk_i),
    .we_i    (wq_we),
    .addr_i  (wq_addr),
    .wdata_i ({sn_q, r_q}),
    .rdata_o (wq_rdata)
  );

  // Output magnitude after the applied gain, clamped to the ceiling.
  always_comb begin
    o_rnd = (mul_p + MP'(1 << 23)) >> 24;
    if (delayed_q[YW-1]) begin
      omag_c = (o_rnd > MP'(ceil_eff)) ? ceil_eff : SB'(o_rnd);
    end else begin
      omag_c = (o_rnd > MP'(pos_lim)) ? pos_lim : SB'(o_rnd);
    end
  end

  // Saturating energy accumulation; the base depends on which meter is due.
  assign nrg_base = (state_q == S_EIN) ? nrg_in_q : nrg_out_q;
  assign nrg_sum  = (NRG_W + 1)'(nrg_base) + (NRG_W + 1)'(mul_p);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ceiling_q   <= CEIL_RST;
      target_q    <= GAIN_RST;
      ramp_q      <= '0;
      la_q        <= LA_RST;
      rf_q        <= RF_RST;
      bg_q        <= GAIN_RST;
      lg_q        <= UNITY24;
      ptr_q       <= '0;
      clr_q       <= '0;
      sn_q        <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      pk_in_q     <= '0;
      pk_out_q    <= '0;
      least_q     <= UNITY16;
      cnt_lim_q   <= '0;
      cnt_all_q   <= '0;
      nrg_in_q    <= '0;
      nrg_out_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CEILING:   ceiling_q <= cfg_data_i[CEIL_W-1:0];
          CFG_TARGET:    target_q  <= cfg_data_i[GAIN_W-1:0];
          CFG_RAMP:      ramp_q    <= cfg_data_i[GAIN_W-1:0];
          CFG_LOOKAHEAD: la_q      <= cfg_data_i[LA_W-1:0];
          CFG_RELEASE:   rf_q      <= cfg_data_i[RF_W-1:0];
          default: ;
        endcase
      end

      // In S_OUT the output register is reloaded below instead.
      if (out_valid_o && !out_stall_i && state_q != S_OUT) begin
        out_valid_o <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == MAX_DELAY - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            ax_q  <= ax_in;
            neg_q <= sample_in_i[SB-1];
            bg_q  <= bg_next;
            if (clear_meters_i) begin
              pk_in_q   <= '0;
              pk_out_q  <= '0;
              least_q   <= UNITY16;
              cnt_lim_q <= '0;
              cnt_all_q <= '0;
              nrg_in_q  <= '0;
              nrg_out_q <= '0;
            end
            state_q <= S_EIN;
          end
        end
        S_EIN: begin
          if (ax_q > pk_in_q) begin
            pk_in_q <= ax_q;
          end
          nrg_in_q <= nrg_sum[NRG_W] ? '1 : nrg_sum[NRG_W-1:0];
          state_q  <= S_BOOST;
        end
        S_BOOST: begin
          y_q     <= neg_q ? YW'(-ymag_c) : ymag_c;
          need_q  <= ymag_c > YW'(ceil_eff);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            r_q       <= need_q ? VW'(div_q) : UNITY16;
            delayed_q <= dly_rdata;
            ptr_q     <= (32'(ptr_q) + 1 >= 32'(len_c)) ? '0 : ptr_q + 1'b1;
            state_q   <= S_POPB;
          end
        end
        S_POPB: begin
          state_q <= (fill_q == '0) ? S_PUSH : S_POPB_CHK;
        end
        S_POPB_CHK: begin
          if (wq_rdata[VW-1:0] < r_q) begin
            state_q <= S_PUSH;
          end else begin
            tail_q  <= last_c;
            fill_q  <= fill_q - 1'b1;
            state_q <= S_POPB;
          end
        end
        S_PUSH: begin
          n_q     <= sn_q;
          sn_q    <= (32'(sn_q) + 1 >= SMOD) ? '0 : sn_q + 1'b1;
          tail_q  <= (32'(tail_q) + 1 >= DQ) ? '0 : tail_q + 1'b1;
          fill_q  <= fill_q + 1'b1;
          state_q <= S_POPF;
        end
        S_POPF: begin
          state_q <= S_POPF_CHK;
        end
        S_POPF_CHK: begin
          // The entry just pushed has age zero, so the deque never empties here.
          if (32'(age_c) < 32'(len_c)) begin
            desired_q <= {wq_rdata[VW-1:0], 8'd0};
            state_q   <= S_REL;
          end else begin
            head_q  <= (32'(head_q) + 1 >= DQ) ? '0 : head_q + 1'b1;
            fill_q  <= fill_q - 1'b1;
            state_q <= S_POPF;
          end
        end
        S_REL: begin
          if (desired_q < lg_q) begin
            lg_q    <= desired_q;
            state_q <= S_OMUL;
          end else begin
            state_q <= S_REL_W;
          end
        end
        S_REL_W: begin
          lg_q    <= lg_q + LG_W'((mul_p + MP'((1 << 24) - 1)) >> 24);
          state_q <= S_OMUL;
        end
        S_OMUL: begin
          state_q <= S_OMUL_W;
        end
        S_OMUL_W: begin
          o_q      <= delayed_q[YW-1] ? SB'(-omag_c) : SB'(omag_c);
          gain16_q <= VW'((lg_q + LG_W'(128)) >> 8);
          lim_q    <= lg_q < LIMIT_THR;
          if (lg_q < LIMIT_THR) begin
            if (cnt_lim_q != '1) begin
              cnt_lim_q <= cnt_lim_q + 1'b1;
            end
            if (VW'((lg_q + LG_W'(128)) >> 8) < least_q) begin
              least_q <= VW'((lg_q + LG_W'(128)) >> 8);
            end
          end
          if (cnt_all_q != '1) begin
            cnt_all_q <= cnt_all_q + 1'b1;
          end
          if (omag_c > pk_out_q) begin
            pk_out_q <= omag_c;
          end
          state_q <= S_EOUT;
        end
        S_EOUT: begin
          nrg_out_q <= nrg_sum[NRG_W] ? '1 : nrg_sum[NRG_W-1:0];
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_o || !out_stall_i) begin
            sample_out_o         <= o_q;
            boost_gain_now_o     <= bg_q;
            limiter_gain_now_o   <= gain16_q;
            is_limiting_o        <= lim_q;
            peak_in_o            <= pk_in_q;
            peak_out_o           <= pk_out_q;
            least_limiter_gain_o <= least_q;
            limited_total_o      <= cnt_lim_q;
            sample_total_o       <= cnt_all_q;
            energy_in_o          <= nrg_in_q;
            energy_out_o         <= nrg_out_q;
            out_valid_o          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/lpl_checker.sv @@
// ----------------------------------------------------------------------------
// Lookahead peak limiter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module lpl_checker import lpl_pkg::*; #(
  parameter int SB = SAMPLE_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic signed [SB-1:0] sample_out_o,
  input logic [G16_W-1:0]     limiter_gain_now_o,
  input logic                 is_limiting_o,
  input logic [G16_W-1:0]     least_limiter_gain_o
);

  // A sample is worked on by a multi-state sequencer, so the block stalls after a transfer.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a sample is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled result dropped or changed");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> limiter_gain_now_o <= UNITY16)
    else $error("limiter gain above unity");

  a_least_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_limiting_o |-> least_limiter_gain_o <= limiter_gain_now_o)
    else $error("least gain meter above the gain applied while limiting");

endmodule

bind lookahead_peak_limiter lpl_checker #(.SB(SAMPLE_BITS)) u_lpl_checker (.*);

@@ bench/tb_lookahead_peak_limiter.sv @@
// ----------------------------------------------------------------------------
// Lookahead peak limiter testbench
// Drives samples through the limiter under several register settings and
// checks every result against a bit-exact predictor held in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lookahead_peak_limiter;
  import lpl_pkg::*;

  localparam int          DEPTH     = 512;
  localparam int unsigned STAMP_MOD = 2 * DEPTH;
  localparam int unsigned DEQ_CAP   = DEPTH + 1;
  localparam longint unsigned CNT_MAX = (64'd1 << 40) - 1;
  localparam longint unsigned NRG_MAX = (64'd1 << 62) - 1;
  localparam int          RAND_ITEMS = 180;
  localparam longint      CYCLE_LIMIT = 4000000;

  // Clock, reset and the two channels.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] sample_in_i = '0;
  logic clear_meters_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] sample_out_o;
  logic [GAIN_W-1:0] boost_gain_now_o;
  logic [G16_W-1:0] limiter_gain_now_o;
  logic is_limiting_o;
  logic [15:0] peak_in_o, peak_out_o;
  logic [G16_W-1:0] least_limiter_gain_o;
  logic [CNT_W-1:0] limited_total_o, sample_total_o;
  logic [NRG_W-1:0] energy_in_o, energy_out_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  lookahead_peak_limiter u_top (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // One limited sample with every meter that travels alongside it. The pinned
  // value is a hand-written output sample for directed rows that have one.
  typedef struct {
    logic signed [15:0] smp;
    logic [19:0]        boost;
    logic [16:0]        gain;
    logic               limiting;
    logic [15:0]        pk_in;
    logic [15:0]        pk_out;
    logic [16:0]        least;
    logic [39:0]        lim_cnt;
    logic [39:0]        tot_cnt;
    logic [61:0]        e_in;
    logic [61:0]        e_out;
    bit                 pinned;
    logic signed [15:0] pin_smp;
  } limited_t;

  limited_t pending_results[$];

  // Register copies held by the predictor.
  int unsigned r_ceil = 32768, r_target = 65536, r_ramp = 0, r_look = 48, r_rel = 2330;

  // Predictor state.
  int unsigned boost = 65536;
  int unsigned lgain = 32'd16777216;
  int          delay_line[DEPTH];
  int unsigned delay_ptr = 0, stamp_now = 0;
  int unsigned win_val[DEQ_CAP], win_stamp[DEQ_CAP];
  int unsigned win_head = 0, win_tail = 0, win_fill = 0;
  int unsigned pk_in = 0, pk_out = 0, least = 65536;
  longint unsigned lim_cnt = 0, tot_cnt = 0, e_in = 0, e_out = 0;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int limited_seen = 0;
  longint cycles = 0;

  initial begin
    foreach (delay_line[i]) delay_line[i] = 0;
  end

  function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b,
                                               longint unsigned top);
    return (a > top - b) ? top : a + b;
  endfunction

  function automatic void zero_meters();
    pk_in = 0;
    pk_out = 0;
    least = 65536;
    lim_cnt = 0;
    tot_cnt = 0;
    e_in = 0;
    e_out = 0;
  endfunction

  // Works out the result of one accepted sample and advances the state.
  function automatic limited_t limit_sample(logic signed [15:0] s, logic clr);
    limited_t res;
    int x, y, delayed, o;
    int unsigned ceff, len, ax, ymag, r, n, last, age, desired, dmag, omag, pos_lim, g16;
    int unsigned ramp_gap;
    longint unsigned p, cap, d;
    x = int'(s);
    ceff = (r_ceil > 32768) ? 32768 : r_ceil;
    len = r_look;
    if (len < 1) len = 1;
    if (len > DEPTH) len = DEPTH;
    if (clr) zero_meters();
    ax = (x < 0) ? -x : x;
    if (ax > pk_in) pk_in = ax;
    e_in = add_sat(e_in, longint'(ax) * ax, NRG_MAX);

    if (boost != r_target) begin
      ramp_gap = (r_target > boost) ? r_target - boost : boost - r_target;
      if (r_ramp == 0 || ramp_gap <= r_ramp) boost = r_target;
      else if (r_target > boost) boost += r_ramp;
      else boost -= r_ramp;
    end

    p = (longint'(ax) * boost + 32768) >> 16;
    cap = (x < 0) ? 1048576 : 1048575;
    if (p > cap) p = cap;
    ymag = p;
    y = (x < 0) ? -int'(ymag) : int'(ymag);

    if (ymag > ceff) r = (longint'(ceff) << 16) / ymag;
    else r = 65536;

    // Sliding minimum of the needed gain over the lookahead window.
    n = stamp_now;
    stamp_now = (n + 1 >= STAMP_MOD) ? 0 : n + 1;
    while (win_fill > 0) begin
      last = (win_tail == 0) ? DEQ_CAP - 1 : win_tail - 1;
      if (win_val[last] < r) break;
      win_tail = last;
      win_fill--;
    end
    win_val[win_tail] = r;
    win_stamp[win_tail] = n;
    win_tail = (win_tail + 1 >= DEQ_CAP) ? 0 : win_tail + 1;
    win_fill++;
    while (win_fill > 0) begin
      age = (n >= win_stamp[win_head]) ? n - win_stamp[win_head]
                                       : n + STAMP_MOD - win_stamp[win_head];
      if (age < len) break;
      win_head = (win_head + 1 >= DEQ_CAP) ? 0 : win_head + 1;
      win_fill--;
    end
    desired = ((win_fill > 0) ? win_val[win_head] : 65536) << 8;

    // Instant attack, rounded-up one-pole release.
    if (desired < lgain) begin
      lgain = desired;
    end else begin
      d = longint'(desired - lgain) * r_rel;
      lgain += (d + 64'd16777215) >> 24;
    end

    delayed = delay_line[delay_ptr];
    delay_line[delay_ptr] = y;
    delay_ptr = (delay_ptr + 1 >= len) ? 0 : delay_ptr + 1;

    dmag = (delayed < 0) ? -delayed : delayed;
    omag = (longint'(dmag) * lgain + 64'd8388608) >> 24;
    pos_lim = (ceff > 32767) ? 32767 : ceff;
    if (delayed < 0) begin
      if (omag > ceff) omag = ceff;
      o = -int'(omag);
    end else begin
      if (omag > pos_lim) omag = pos_lim;
      o = omag;
    end

    g16 = (lgain + 128) >> 8;
    res.limiting = (lgain < 32'd16760439);
    if (res.limiting) begin
      lim_cnt = add_sat(lim_cnt, 1, CNT_MAX);
      if (g16 < least) least = g16;
    end
    tot_cnt = add_sat(tot_cnt, 1, CNT_MAX);
    if (omag > pk_out) pk_out = omag;
    e_out = add_sat(e_out, longint'(omag) * omag, NRG_MAX);

    res.smp = o[15:0];
    res.boost = boost[19:0];
    res.gain = g16[16:0];
    res.pk_in = pk_in[15:0];
    res.pk_out = pk_out[15:0];
    res.least = least[16:0];
    res.lim_cnt = lim_cnt[39:0];
    res.tot_cnt = tot_cnt[39:0];
    res.e_in = e_in[61:0];
    res.e_out = e_out[61:0];
    res.pinned = 1'b0;
    res.pin_smp = '0;
    return res;
  endfunction

  // Sender: one transfer, then the predicted result is queued.
  int burst_left = 0;

  task automatic send_sample(logic signed [15:0] s, logic clr, bit pin,
                             logic signed [15:0] pin_val);
    limited_t res;
    int gap;
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    clear_meters_i <= clr;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    res = limit_sample(s, clr);
    res.pinned = pin;
    res.pin_smp = pin_val;
    pending_results.push_back(res);
    items_sent++;
    @(posedge clk_i);
    // Bursts of back-to-back transfers, separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(0, 12);
      gap = $urandom_range(1, 25);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_CEILING:   r_ceil = val & 32'hFFFF;
      CFG_TARGET:    r_target = val & 32'hFFFFF;
      CFG_RAMP:      r_ramp = val & 32'hFFFFF;
      CFG_LOOKAHEAD: r_look = val & 32'h3FF;
      CFG_RELEASE:   r_rel = val & 32'hFFFFFF;
      default: ;
    endcase
  endtask

  // Waits until every predicted result has been taken, so the block is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_sample();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: return 16'($urandom_range(0, 65535));
      3: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd32767;
          default: return 16'sd0;
        endcase
      end
      4, 5: return 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(20000, 32767)));
      default: return 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 2000)));
    endcase
  endfunction

  // Directed rows straight after reset. The lookahead delay of 48 samples is
  // still filled with silence, so every output sample here must be zero.
  typedef struct {
    logic signed [15:0] smp;
    logic               clr;
  } row_t;

  row_t opening_rows[] = '{
    '{16'sd0, 1'b0}, '{16'sd32767, 1'b0}, '{-16'sd32768, 1'b0}, '{-16'sd32767, 1'b0},
    '{16'sd1, 1'b0}, '{-16'sd1, 1'b0}, '{16'sd16384, 1'b0}, '{-16'sd16384, 1'b1},
    '{16'sh5555, 1'b0}, '{16'sh2AAA, 1'b0}, '{-16'sd21846, 1'b0}, '{16'sd100, 1'b1},
    '{16'sd32767, 1'b0}, '{16'sd32767, 1'b0}, '{16'sd0, 1'b0}, '{-16'sd32768, 1'b0},
    '{16'sd12345, 1'b0}, '{-16'sd4321, 1'b0}, '{16'sd7, 1'b0}, '{16'sd30000, 1'b1}
  };

  // Register settings, one per phase: ceiling, target, ramp, lookahead, release.
  typedef int unsigned setting_t[5];
  setting_t settings[] = '{
    '{32768, 65536, 0, 48, 2330},
    '{16384, 262144, 1000, 16, 1048576},
    '{0, 1048575, 0, 1, 16777215},
    '{65535, 0, 1048575, 512, 0},
    '{8000, 131072, 37, 1023, 50000},
    '{1, 200000, 3000, 0, 8000000},
    '{32768, 98304, 0, 512, 16777215},
    '{20000, 150000, 500, 5, 300000}
  };

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i]) begin
      send_sample(opening_rows[i].smp, opening_rows[i].clr, 1'b1, 16'sd0);
    end
    for (int k = 0; k < RAND_ITEMS; k++) begin
      send_sample(pick_sample(), $urandom_range(0, 49) == 0, 1'b0, '0);
    end

    // Fixed settings first, then a couple of random ones.
    for (int ph = 0; ph < settings.size() + 2; ph++) begin
      setting_t st;
      if (ph < settings.size()) begin
        st = settings[ph];
      end else begin
        st = '{$urandom_range(0, 32768), $urandom_range(0, 1048575),
               $urandom_range(0, 20000), $urandom_range(1, 512),
               $urandom_range(0, 16777215)};
      end
      drain();
      write_reg(CFG_CEILING, st[0]);
      write_reg(CFG_TARGET, st[1]);
      write_reg(CFG_RAMP, st[2]);
      write_reg(CFG_LOOKAHEAD, st[3]);
      write_reg(CFG_RELEASE, st[4]);
      cfg_we_i <= 1'b0;
      for (int k = 0; k < RAND_ITEMS; k++) begin
        send_sample(pick_sample(), $urandom_range(0, 49) == 0, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    $display("Covered %0d samples over %0d register settings; %0d results checked,",
             items_sent, settings.size() + 3, results_seen);
    $display("%0d of them taken while the limiter was pulling the gain down.", limited_seen);
    if (errors == 0) begin
      $display("lookahead_peak_limiter: match");
    end else begin
      $display("lookahead_peak_limiter: mismatch");
    end
    $finish;
  end

  // Receiver stall pattern: switches at random between free flow, light, heavy
  // and long stalls.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ($urandom_range(0, 40) != 0);
    endcase
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Results are sampled at the falling edge, where outputs and the stall are
  // settled; a transfer then completes on the following rising edge.
  always @(negedge clk_i) begin
    limited_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no sample outstanding, got sample %0h",
                 $time, sample_out_o);
      end else begin
        want = pending_results.pop_front();
        if (is_limiting_o) limited_seen++;
        if (want.pinned) check_field("pinned sample_out", 64'(want.pin_smp), 64'(sample_out_o));
        check_field("sample_out", 64'(want.smp), 64'(sample_out_o));
        check_field("boost_gain_now", 64'(want.boost), 64'(boost_gain_now_o));
        check_field("limiter_gain_now", 64'(want.gain), 64'(limiter_gain_now_o));
        check_field("is_limiting", 64'(want.limiting), 64'(is_limiting_o));
        check_field("peak_in", 64'(want.pk_in), 64'(peak_in_o));
        check_field("peak_out", 64'(want.pk_out), 64'(peak_out_o));
        check_field("least_limiter_gain", 64'(want.least), 64'(least_limiter_gain_o));
        check_field("limited_total", 64'(want.lim_cnt), 64'(limited_total_o));
        check_field("sample_total", 64'(want.tot_cnt), 64'(sample_total_o));
        check_field("energy_in", 64'(want.e_in), 64'(energy_in_o));
        check_field("energy_out", 64'(want.e_out), 64'(energy_out_o));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycles, pending_results.size());
      $display("lookahead_peak_limiter: mismatch");
      $finish;
    end
  end

endmodule

@@ files.f @@
src/lpl_pkg.sv
src/lpl_ram.sv
src/lpl_mul.sv
src/lpl_div.sv
src/lookahead_peak_limiter.sv
src/lpl_checker.sv
bench/tb_lookahead_peak_limiter.sv
